@@ hdl/dss_pkg.sv @@
// shared types, command and status codes for the dual stack block
package dss_pkg;

    localparam int CNT_W    = 11;
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_DATA_BITS   = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH_LOW   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_HIGH  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_LOW    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_HIGH   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR_LOW  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR_HIGH = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR_BOTH = 3'd6;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] push_data;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   low_top;
        logic                low_top_valid;
        logic [WORD_W-1:0]   high_top;
        logic                high_top_valid;
        logic [CNT_W-1:0]    low_count;
        logic [CNT_W-1:0]    high_count;
        logic [CNT_W-1:0]    total_count;
        logic                is_full;
        logic                is_empty;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic fetch;
    } ctrl_t;

endpackage

@@ hdl/dual_stack_shared_memory.sv @@
// a command passes execute, top fetch and respond states; the result strobe is in respond
// busy is high in execute and top fetch, so no new command is taken until the result cycle
// the next command may be transferred in the result cycle; results cannot be stalled
// reset: asynchronous active low, stacks empty and capacity 1024; memory contents undefined
// a capacity write clears both stacks at once, no clearing pass over the memory
module dual_stack_shared_memory #(
    parameter int MAX_ENTRIES = dss_pkg::DEF_MAX_ENTRIES,
    parameter int DATA_BITS   = dss_pkg::DEF_DATA_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // command transfer
    input  logic                      start,
    output logic                      busy,
    input  dss_pkg::request_t         request,
    // result transfer, one cycle strobe
    output logic                      done,
    output dss_pkg::result_t          result,
    // capacity register write
    input  logic                      cfg_we,
    input  logic [dss_pkg::CNT_W-1:0] cfg_data
);

    // command group from sequencer to datapath
    dss_pkg::ctrl_t ctl;

    // sequencer: idle, execute (pointer update and write), fetch (top reads), respond
    dss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // low stack grows up from entry 0, high stack grows down from capacity - 1
    dss_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

@@ hdl/dss_ctrl.sv @@
// command sequencer: capture, execute, fetch tops, respond
module dss_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output dss_pkg::ctrl_t ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg == ST_EXEC) || (state_reg == ST_READ);
    assign accept = start && !busy;
    assign done   = (state_reg == ST_RESP);

    assign ctl.capture = accept;
    assign ctl.execute = (state_reg == ST_EXEC);
    assign ctl.fetch   = (state_reg == ST_READ);

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_RESP;
            ST_RESP: state_next = accept ? ST_EXEC : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctl.execute)
        else $error("accepted command did not execute");

    a_exec_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |=> ctl.fetch)
        else $error("execute not followed by fetch");

    a_done_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctl.fetch))
        else $error("result strobe without fetch");
`endif

endmodule

@@ hdl/dss_datapath.sv @@
// stack pointers, shared entry memory and result assembly
module dss_datapath #(
    parameter int MAX_ENTRIES = dss_pkg::DEF_MAX_ENTRIES,
    parameter int DATA_BITS   = dss_pkg::DEF_DATA_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dss_pkg::ctrl_t               ctl,
    input  dss_pkg::request_t            request,
    input  logic                         cfg_we,
    input  logic [dss_pkg::CNT_W-1:0]    cfg_data,
    output dss_pkg::result_t             result
);

    localparam int CW  = dss_pkg::CNT_W;
    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int XAW = (AW > CW) ? AW : CW;
    localparam int XDW = (DATA_BITS > dss_pkg::WORD_W) ? DATA_BITS : dss_pkg::WORD_W;
    localparam logic [CW-1:0] MAX_CAP =
        (MAX_ENTRIES >= (1 << CW)) ? {CW{1'b1}} : CW'(MAX_ENTRIES);

    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] v);
        logic [XAW-1:0] x;
        x = XAW'(v);
        return x[AW-1:0];
    endfunction

    logic [DATA_BITS-1:0] mem [MAX_ENTRIES];

    dss_pkg::request_t             req_reg;
    logic [CW-1:0]                 cap_reg;
    logic [CW-1:0]                 low_depth_reg;
    logic [CW-1:0]                 low_depth_next;
    logic [CW-1:0]                 high_depth_reg;
    logic [CW-1:0]                 high_depth_next;
    logic [dss_pkg::STATUS_W-1:0]  status_reg;
    logic [dss_pkg::STATUS_W-1:0]  status_next;
    logic [DATA_BITS-1:0]          rd_low_reg;
    logic [DATA_BITS-1:0]          rd_high_reg;

    logic [CW-1:0]        eff_cap;
    logic [CW-1:0]        total;
    logic                 full;
    logic                 mem_we;
    logic [AW-1:0]        waddr;
    logic [XDW-1:0]       wdata_x;
    logic [XDW-1:0]       rd_low_x;
    logic [XDW-1:0]       rd_high_x;

    assign eff_cap = (cap_reg > MAX_CAP) ? MAX_CAP : cap_reg;
    assign total   = low_depth_reg + high_depth_reg;
    assign full    = (total >= eff_cap);
    assign wdata_x = XDW'(req_reg.push_data);

    always_comb
    begin
        low_depth_next  = low_depth_reg;
        high_depth_next = high_depth_reg;
        status_next     = dss_pkg::STAT_DONE;
        mem_we          = 1'b0;
        waddr           = to_addr(low_depth_reg);
        case (req_reg.cmd)
            dss_pkg::CMD_PUSH_LOW:
            begin
                if (full)
                begin
                    status_next = dss_pkg::STAT_FULL;
                end
                else
                begin
                    mem_we         = 1'b1;
                    low_depth_next = low_depth_reg + 1'b1;
                end
            end
            dss_pkg::CMD_PUSH_HIGH:
            begin
                high_depth_next = high_depth_reg + 1'b1;
                waddr           = to_addr(eff_cap - high_depth_next);
                if (full)
                begin
                    status_next     = dss_pkg::STAT_FULL;
                    high_depth_next = high_depth_reg;
                end
                else
                begin
                    mem_we = 1'b1;
                end
            end
            dss_pkg::CMD_POP_LOW:
            begin
                if (low_depth_reg == '0)
                begin
                    status_next = dss_pkg::STAT_EMPTY;
                end
                else
                begin
                    low_depth_next = low_depth_reg - 1'b1;
                end
            end
            dss_pkg::CMD_POP_HIGH:
            begin
                if (high_depth_reg == '0)
                begin
                    status_next = dss_pkg::STAT_EMPTY;
                end
                else
                begin
                    high_depth_next = high_depth_reg - 1'b1;
                end
            end
            dss_pkg::CMD_CLEAR_LOW:  low_depth_next = '0;
            dss_pkg::CMD_CLEAR_HIGH: high_depth_next = '0;
            dss_pkg::CMD_CLEAR_BOTH:
            begin
                low_depth_next  = '0;
                high_depth_next = '0;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= dss_pkg::CAP_RESET;
            low_depth_reg  <= '0;
            high_depth_reg <= '0;
        end
        else if (cfg_we)
        begin
            cap_reg        <= cfg_data;
            low_depth_reg  <= '0;
            high_depth_reg <= '0;
        end
        else if (ctl.execute)
        begin
            low_depth_reg  <= low_depth_next;
            high_depth_reg <= high_depth_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= request;
        end
        if (ctl.execute)
        begin
            status_reg <= status_next;
        end
    end

    // entry memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (ctl.execute && mem_we)
        begin
            mem[waddr] <= wdata_x[DATA_BITS-1:0];
        end
        if (ctl.fetch)
        begin
            rd_low_reg  <= mem[to_addr(low_depth_reg - 1'b1)];
            rd_high_reg <= mem[to_addr(eff_cap - high_depth_reg)];
        end
    end

    assign rd_low_x  = XDW'(rd_low_reg);
    assign rd_high_x = XDW'(rd_high_reg);

    always_comb
    begin
        result.status         = status_reg;
        result.low_top_valid  = (low_depth_reg != '0);
        result.high_top_valid = (high_depth_reg != '0);
        result.low_top        = result.low_top_valid ? rd_low_x[dss_pkg::WORD_W-1:0] : '0;
        result.high_top       = result.high_top_valid ? rd_high_x[dss_pkg::WORD_W-1:0] : '0;
        result.low_count      = low_depth_reg;
        result.high_count     = high_depth_reg;
        result.total_count    = total;
        result.is_full        = full;
        result.is_empty       = (total == '0);
    end

`ifndef SYNTHESIS
    a_total_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, low_depth_reg} + {1'b0, high_depth_reg}) <= {1'b0, eff_cap})
        else $error("stacks overlap beyond capacity");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && !cfg_we && req_reg.cmd == dss_pkg::CMD_POP_LOW &&
         low_depth_reg == '0)
        |=> (status_reg == dss_pkg::STAT_EMPTY) && (low_depth_reg == '0))
        else $error("pop from empty low stack not refused");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.execute && !cfg_we && full &&
         (req_reg.cmd == dss_pkg::CMD_PUSH_LOW || req_reg.cmd == dss_pkg::CMD_PUSH_HIGH))
        |=> (status_reg == dss_pkg::STAT_FULL) && (total == $past(total)))
        else $error("push into full memory not refused");
`endif

endmodule
